// File: rtl/core/paged_kv_gather_address_gen_defines.svh
// Assertion macros for the gather address generator
`ifndef PAGED_KV_GATHER_ADDRESS_GEN_DEFINES_SVH
`define PAGED_KV_GATHER_ADDRESS_GEN_DEFINES_SVH
// implication checked every edge outside reset
`define PKG_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define PKG_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: rtl/core/pkvg_pkg.sv
package pkvg_pkg;
    localparam int SOURCE_MAP_DEPTH = 1024;
    localparam int TARGET_MAP_DEPTH = 1024;
    localparam int SLOT_COUNT = 10 * 1024;
    localparam int QUERIES_PER_ROW = 2 * 1024;
    localparam int CNT_HW_MAX = 4095;
    localparam int CFG_W = 11;
    localparam int ADDR_W = 52;
    localparam int PADDR_W = 5;

    typedef enum logic [1:0] {
        ACT_SRC_WR = 2'd0,
        ACT_DST_WR = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_SRC_BS  = 3'd0,
        REG_SRC_BPR = 3'd1,
        REG_DST_BS  = 3'd2,
        REG_DST_BPR = 3'd3,
        REG_KV_W    = 3'd4,
        REG_ROPE_W  = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_RD, ST_RDW, ST_MUL1, ST_MUL2, ST_MUL3, ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] src_bs;
        logic [CFG_W-1:0] src_bpr;
        logic [CFG_W-1:0] dst_bs;
        logic [CFG_W-1:0] dst_bpr;
        logic [CFG_W-1:0] kv_w;
        logic [CFG_W-1:0] rope_w;
    } cfg_t;

    // queued query after front checks
    typedef struct packed {
        logic        check;   // passed front checks
        logic [30:0] token;
        logic [30:0] slot;
        logic        last;
    } query_t;

    typedef struct packed {
        logic              copy_valid;
        logic [ADDR_W-1:0] src_kv_addr;
        logic [ADDR_W-1:0] src_rope_addr;
        logic [ADDR_W-1:0] dst_kv_addr;
        logic [ADDR_W-1:0] dst_rope_addr;
        logic              row_done;
        logic [11:0]       copied_count;
    } result_t;
endpackage

// File: rtl/core/pkvg_if.sv
interface pkvg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [9:0]  table_index;
    logic signed [31:0] table_value;
    logic        miss;
    logic signed [31:0] token;
    logic signed [31:0] slot;
    logic [30:0] seq_len;
    logic        last;
    modport source (output valid, action, table_index, table_value, miss, token, slot,
                    seq_len, last, input ready);
    modport sink (input valid, action, table_index, table_value, miss, token, slot,
                  seq_len, last, output ready);
endinterface

interface pkvg_out_if;
    logic        valid;
    logic        ready;
    logic        copy_valid;
    logic [51:0] src_kv_addr;
    logic [51:0] src_rope_addr;
    logic [51:0] dst_kv_addr;
    logic [51:0] dst_rope_addr;
    logic        row_done;
    logic [11:0] copied_count;
    modport source (output valid, copy_valid, src_kv_addr, src_rope_addr, dst_kv_addr,
                    dst_rope_addr, row_done, copied_count, input ready);
    modport sink (input valid, copy_valid, src_kv_addr, src_rope_addr, dst_kv_addr,
                  dst_rope_addr, row_done, copied_count, output ready);
endinterface

// File: rtl/core/paged_kv_gather_address_gen.sv
// Paged KV gather address generator.
// in_ch: table writes (action 0/1) load the source/target block maps;
//   queries (action 2) with miss or last set give one result beat each.
// out_ch: copy_valid, four element base addresses, row_done, copied_count.
// Config over APB, registers at 4*i, which the user must write only while idle;
//   the block does not enforce this. A query rejected at entry goes straight to
//   the output stage; a checked query makes two passes of the shared 31-step
//   divider, then a map read and three multiply/add stages (MUL1 to MUL3).
// The back end handles one query at a time; a table write is accepted only
//   once no query is pending, so it never overtakes a queued query.
// A two-entry queue sits between front and back; queries are accepted while
//   the queue has room, table writes only while it is empty.
// Output is registered; a stalled receiver holds the beat and, once the
//   queue fills, backpressures the input.
// Reset clears registers to defaults, the copy counter and the queue;
//   map contents stay undefined until written.
module paged_kv_gather_address_gen #(
    parameter int SOURCE_MAP_DEPTH = pkvg_pkg::SOURCE_MAP_DEPTH,
    parameter int TARGET_MAP_DEPTH = pkvg_pkg::TARGET_MAP_DEPTH,
    parameter int SLOT_COUNT       = pkvg_pkg::SLOT_COUNT,
    parameter int QUERIES_PER_ROW  = pkvg_pkg::QUERIES_PER_ROW
) (
    input  logic        clk,
    input  logic        rst_n,
    pkvg_in_if.sink     in_ch,
    pkvg_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [pkvg_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SAW = $clog2(SOURCE_MAP_DEPTH);
    localparam int TAW = $clog2(TARGET_MAP_DEPTH);

    pkvg_pkg::cfg_t   cfg_reg;
    pkvg_pkg::query_t q_data;
    logic        q_valid, q_pop;
    logic        src_we, dst_we, src_we_ok, dst_we_ok;
    logic [9:0]  wr_index;
    logic [31:0] wr_value, src_rdata, dst_rdata;
    logic [SAW-1:0] src_raddr;
    logic [TAW-1:0] dst_raddr;
    logic        div_start, div_done;
    logic [30:0] div_dividend, div_quo;
    logic [10:0] div_divisor, div_rem;
    logic [2:0]  reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{src_bs: 11'd128, src_bpr: 11'd1024, dst_bs: 11'd128,
                         dst_bpr: 11'd1024, kv_w: 11'd512, rope_w: 11'd64};
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                pkvg_pkg::REG_SRC_BS:  cfg_reg.src_bs  <= pwdata[10:0];
                pkvg_pkg::REG_SRC_BPR: cfg_reg.src_bpr <= pwdata[10:0];
                pkvg_pkg::REG_DST_BS:  cfg_reg.dst_bs  <= pwdata[10:0];
                pkvg_pkg::REG_DST_BPR: cfg_reg.dst_bpr <= pwdata[10:0];
                pkvg_pkg::REG_KV_W:    cfg_reg.kv_w    <= pwdata[10:0];
                pkvg_pkg::REG_ROPE_W:  cfg_reg.rope_w  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            pkvg_pkg::REG_SRC_BS:  prdata = 32'(cfg_reg.src_bs);
            pkvg_pkg::REG_SRC_BPR: prdata = 32'(cfg_reg.src_bpr);
            pkvg_pkg::REG_DST_BS:  prdata = 32'(cfg_reg.dst_bs);
            pkvg_pkg::REG_DST_BPR: prdata = 32'(cfg_reg.dst_bpr);
            pkvg_pkg::REG_KV_W:    prdata = 32'(cfg_reg.kv_w);
            pkvg_pkg::REG_ROPE_W:  prdata = 32'(cfg_reg.rope_w);
            default: prdata = '0;
        endcase
    end

    pkvg_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
        .clk, .rst_n, .in_ch, .cfg(cfg_reg), .src_we, .dst_we, .wr_index, .wr_value,
        .q_valid, .q_data, .q_pop
    );

    assign src_we_ok = src_we && 17'(wr_index) < 17'(SOURCE_MAP_DEPTH);
    assign dst_we_ok = dst_we && 17'(wr_index) < 17'(TARGET_MAP_DEPTH);

    pkvg_ram #(.WIDTH(32), .DEPTH(SOURCE_MAP_DEPTH)) u_src_map (
        .clk, .we(src_we_ok), .waddr(SAW'(wr_index)), .wdata(wr_value),
        .raddr(src_raddr), .rdata(src_rdata)
    );

    pkvg_ram #(.WIDTH(32), .DEPTH(TARGET_MAP_DEPTH)) u_dst_map (
        .clk, .we(dst_we_ok), .waddr(TAW'(wr_index)), .wdata(wr_value),
        .raddr(dst_raddr), .rdata(dst_rdata)
    );

    pkvg_divider u_div (
        .clk, .rst_n, .start(div_start), .dividend(div_dividend), .divisor(div_divisor),
        .done(div_done), .quotient(div_quo), .remainder(div_rem)
    );

    pkvg_back #(
        .SOURCE_MAP_DEPTH(SOURCE_MAP_DEPTH), .TARGET_MAP_DEPTH(TARGET_MAP_DEPTH),
        .QUERIES_PER_ROW(QUERIES_PER_ROW)
    ) u_back (
        .clk, .rst_n, .cfg(cfg_reg), .q_valid, .q_data, .q_pop,
        .div_dividend, .div_divisor, .div_start, .div_done, .div_quo, .div_rem,
        .src_raddr, .dst_raddr, .src_rdata, .dst_rdata, .out_ch
    );
endmodule

// File: rtl/core/pkvg_ram.sv
module pkvg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/pkvg_divider.sv
// restoring divider, one quotient bit per cycle, 31-bit dividend
module pkvg_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] dividend,
    input  logic [10:0] divisor,
    output logic        done,
    output logic [30:0] quotient,
    output logic [10:0] remainder
);
    logic [30:0] quo_reg, quo_next;
    logic [11:0] rem_reg, rem_next;
    logic [10:0] div_reg, div_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [11:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = 5'd30;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg[10:0], quo_reg[30]};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = trial - {1'b0, div_reg};
                quo_next = {quo_reg[29:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[29:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[10:0];
endmodule

// File: rtl/core/pkvg_front.sv
// front: table writes, range checks, queueing of queries
module pkvg_front #(
    parameter int SLOT_COUNT = pkvg_pkg::SLOT_COUNT
) (
    input  logic               clk,
    input  logic               rst_n,
    pkvg_in_if.sink            in_ch,
    input  pkvg_pkg::cfg_t     cfg,
    output logic               src_we,
    output logic               dst_we,
    output logic [9:0]         wr_index,
    output logic [31:0]        wr_value,
    output logic               q_valid,
    output pkvg_pkg::query_t   q_data,
    input  logic               q_pop
);
    pkvg_pkg::query_t fifo_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, is_query, is_write, ok;

    assign is_query = in_ch.action == pkvg_pkg::ACT_QUERY && (in_ch.miss || in_ch.last);
    assign is_write = in_ch.action == pkvg_pkg::ACT_SRC_WR
        || in_ch.action == pkvg_pkg::ACT_DST_WR;
    // map writes wait until no query is pending
    assign in_ch.ready = cnt_reg != 2'd2 && (!is_write || cnt_reg == 2'd0);
    assign push = in_ch.valid && in_ch.ready && is_query;
    assign src_we = in_ch.valid && in_ch.ready && in_ch.action == pkvg_pkg::ACT_SRC_WR;
    assign dst_we = in_ch.valid && in_ch.ready && in_ch.action == pkvg_pkg::ACT_DST_WR;
    assign wr_index = in_ch.table_index;
    assign wr_value = in_ch.table_value;

    assign ok = in_ch.miss && !in_ch.token[31] && (in_ch.token[30:0] < in_ch.seq_len)
        && !in_ch.slot[31] && (in_ch.slot[30:0] < 31'(SLOT_COUNT))
        && cfg.src_bs != '0 && cfg.dst_bs != '0;

    assign q_valid = cnt_reg != 2'd0;
    assign q_data  = fifo_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= '{check: ok, token: in_ch.token[30:0],
                                  slot: in_ch.slot[30:0], last: in_ch.last};
        end
    end
endmodule

// File: rtl/core/pkvg_back.sv
// back: divide, translate, multiply, count, output register
module pkvg_back #(
    parameter int SOURCE_MAP_DEPTH = pkvg_pkg::SOURCE_MAP_DEPTH,
    parameter int TARGET_MAP_DEPTH = pkvg_pkg::TARGET_MAP_DEPTH,
    parameter int QUERIES_PER_ROW  = pkvg_pkg::QUERIES_PER_ROW
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pkvg_pkg::cfg_t   cfg,
    input  logic             q_valid,
    input  pkvg_pkg::query_t q_data,
    output logic             q_pop,
    output logic [30:0]      div_dividend,
    output logic [10:0]      div_divisor,
    output logic             div_start,
    input  logic             div_done,
    input  logic [30:0]      div_quo,
    input  logic [10:0]      div_rem,
    output logic [$clog2(SOURCE_MAP_DEPTH)-1:0] src_raddr,
    output logic [$clog2(TARGET_MAP_DEPTH)-1:0] dst_raddr,
    input  logic [31:0]      src_rdata,
    input  logic [31:0]      dst_rdata,
    pkvg_out_if.source       out_ch
);
    localparam int LIMIT = QUERIES_PER_ROW < pkvg_pkg::CNT_HW_MAX ?
                           QUERIES_PER_ROW : pkvg_pkg::CNT_HW_MAX;
    localparam int SAW = $clog2(SOURCE_MAP_DEPTH);
    localparam int TAW = $clog2(TARGET_MAP_DEPTH);

    pkvg_pkg::back_state_t state_reg, state_next;
    logic        phase_reg, phase_next;
    logic        ok_reg, ok_next;
    logic [30:0] sblk_reg, sblk_next, tblk_reg, tblk_next;
    logic [10:0] soff_reg, soff_next, toff_reg, toff_next;
    logic [51:0] sbase_reg, sbase_next, tbase_reg, tbase_next;
    logic [11:0] cnt_reg, cnt_next;
    logic        ovalid_reg, ovalid_next;
    pkvg_pkg::result_t res_reg, res_next;
    logic [51:0] a0_reg, a1_reg, a2_reg, a3_reg;
    logic [51:0] a0_next, a1_next, a2_next, a3_next;
    logic        sblk_ok, tblk_ok;

    assign div_dividend = phase_next ? q_data.slot : q_data.token;
    assign div_divisor  = phase_next ? cfg.dst_bs : cfg.src_bs;
    assign src_raddr = sblk_reg[SAW-1:0];
    assign dst_raddr = tblk_reg[TAW-1:0];
    assign sblk_ok = sblk_reg < 31'({20'd0, cfg.src_bpr})
        && sblk_reg < 31'(SOURCE_MAP_DEPTH);
    assign tblk_ok = tblk_reg < 31'({20'd0, cfg.dst_bpr})
        && tblk_reg < 31'(TARGET_MAP_DEPTH);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        ok_next     = ok_reg;
        sblk_next   = sblk_reg;
        tblk_next   = tblk_reg;
        soff_next   = soff_reg;
        toff_next   = toff_reg;
        sbase_next  = sbase_reg;
        tbase_next  = tbase_reg;
        a0_next = a0_reg; a1_next = a1_reg; a2_next = a2_reg; a3_next = a3_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        res_next    = res_reg;
        div_start   = 1'b0;
        q_pop       = 1'b0;
        unique case (state_reg)
            pkvg_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    ok_next = q_data.check;
                    phase_next = 1'b0;
                    if (q_data.check)
                    begin
                        div_start  = 1'b1;
                        state_next = pkvg_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = pkvg_pkg::ST_OUT;
                    end
                end
            end
            pkvg_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (!phase_reg)
                    begin
                        sblk_next  = div_quo;
                        soff_next  = div_rem;
                        phase_next = 1'b1;
                        div_start  = 1'b1;
                    end
                    else
                    begin
                        tblk_next  = div_quo;
                        toff_next  = div_rem;
                        state_next = pkvg_pkg::ST_RD;
                    end
                end
            end
            pkvg_pkg::ST_RD:
            begin
                ok_next = sblk_ok && tblk_ok;
                state_next = (sblk_ok && tblk_ok) ? pkvg_pkg::ST_RDW : pkvg_pkg::ST_OUT;
            end
            pkvg_pkg::ST_RDW:
            begin
                ok_next = !src_rdata[31] && !dst_rdata[31];
                state_next = pkvg_pkg::ST_MUL1;
            end
            pkvg_pkg::ST_MUL1:
            begin
                sbase_next = 52'(src_rdata[30:0] * cfg.src_bs);
                tbase_next = 52'(dst_rdata[30:0] * cfg.dst_bs);
                state_next = pkvg_pkg::ST_MUL2;
            end
            pkvg_pkg::ST_MUL2:
            begin
                sbase_next = sbase_reg + 52'(soff_reg);
                tbase_next = tbase_reg + 52'(toff_reg);
                state_next = pkvg_pkg::ST_MUL3;
            end
            pkvg_pkg::ST_MUL3:
            begin
                a0_next = 52'(sbase_reg[41:0] * cfg.kv_w);
                a1_next = 52'(sbase_reg[41:0] * cfg.rope_w);
                a2_next = 52'(tbase_reg[41:0] * cfg.kv_w);
                a3_next = 52'(tbase_reg[41:0] * cfg.rope_w);
                state_next = pkvg_pkg::ST_OUT;
            end
            pkvg_pkg::ST_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    res_next.copy_valid    = ok_reg;
                    res_next.src_kv_addr   = ok_reg ? a0_reg : '0;
                    res_next.src_rope_addr = ok_reg ? a1_reg : '0;
                    res_next.dst_kv_addr   = ok_reg ? a2_reg : '0;
                    res_next.dst_rope_addr = ok_reg ? a3_reg : '0;
                    res_next.row_done      = q_data.last;
                    if (ok_reg && cnt_reg < 12'(LIMIT))
                    begin
                        res_next.copied_count = cnt_reg + 12'd1;
                    end
                    else
                    begin
                        res_next.copied_count = cnt_reg;
                    end
                    cnt_next    = q_data.last ? '0 : res_next.copied_count;
                    ovalid_next = 1'b1;
                    q_pop       = 1'b1;
                    state_next  = pkvg_pkg::ST_IDLE;
                end
            end
            default: state_next = pkvg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pkvg_pkg::ST_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        ok_reg    <= ok_next;
        sblk_reg  <= sblk_next;
        tblk_reg  <= tblk_next;
        soff_reg  <= soff_next;
        toff_reg  <= toff_next;
        sbase_reg <= sbase_next;
        tbase_reg <= tbase_next;
        a0_reg <= a0_next; a1_reg <= a1_next; a2_reg <= a2_next; a3_reg <= a3_next;
        res_reg   <= res_next;
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.copy_valid    = res_reg.copy_valid;
    assign out_ch.src_kv_addr   = res_reg.src_kv_addr;
    assign out_ch.src_rope_addr = res_reg.src_rope_addr;
    assign out_ch.dst_kv_addr   = res_reg.dst_kv_addr;
    assign out_ch.dst_rope_addr = res_reg.dst_rope_addr;
    assign out_ch.row_done      = res_reg.row_done;
    assign out_ch.copied_count  = res_reg.copied_count;
endmodule

// File: rtl/core/pkvg_checker.sv
`include "paged_kv_gather_address_gen_defines.svh"
module pkvg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        copy_valid,
    input logic [51:0] src_kv_addr,
    input logic [51:0] dst_kv_addr,
    input logic        row_done,
    input logic [11:0] copied_count,
    input logic        pready
);
    `PKG_ASSERT_IMP(a_rej_zero, clk, rst_n, out_valid && !copy_valid, (src_kv_addr | dst_kv_addr) == '0)
    `PKG_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(copied_count))
    `PKG_ASSERT_NEXT(a_hold_row, clk, rst_n, out_valid && !out_ready, $stable(row_done))
    `PKG_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)
endmodule

bind paged_kv_gather_address_gen pkvg_checker u_chk (
    .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .copy_valid(out_ch.copy_valid), .src_kv_addr(out_ch.src_kv_addr),
    .dst_kv_addr(out_ch.dst_kv_addr), .row_done(out_ch.row_done),
    .copied_count(out_ch.copied_count), .pready
);
